// ----- sv/ttf_pkg.sv -----
// Package for the triangle tangent frame block: widths, command and status
// structs shared by the controller, datapath and top level. No dependencies.
`timescale 1ns / 1ps

package ttf_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned TexW   = 20;
  localparam int unsigned OutW   = 16;
  localparam int unsigned MulIdxW = 4;
  localparam int unsigned NumProd = 14;

  // controller -> datapath commands
  typedef struct packed {
    logic                 hold_we;
    logic                 hold_slot;
    logic                 start;
    logic                 mul_issue;
    logic [MulIdxW-1:0]   mul_idx;
    logic                 load_vec;
    logic                 vec_sel;
    logic                 shift;
    logic                 sq_issue;
    logic [1:0]           comp;
    logic                 sqrt_init;
    logic                 sqrt_step;
    logic                 div_init;
    logic                 div_step;
    logic                 div_wr;
    logic                 out_load;
    logic                 out_degen;
  } ttf_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic need_shift;
    logic out_busy;
  } ttf_sts_t;

endpackage

// ----- sv/triangle_tangent_frame_core.sv -----
// Triangle tangent frame core: one vertex per item, one result per triangle.
// Vertices 1 and 2 of a triangle are taken into holding registers. The third vertex starts
// a sequence on one shared multiplier, a separate squarer, a 1-bit/cycle square root and a
// 1-bit/cycle divider; a zero determinant ends it early with a degenerate result. No new
// vertex is taken until the result of the triangle has been loaded into the output register.
// Reset (rst_ni low, asynchronous) clears the vertex count and the result valid.
`timescale 1ns / 1ps

module triangle_tangent_frame_core import ttf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic signed [TexW-1:0] tex_u_i,
  input  logic signed [TexW-1:0] tex_v_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] tangent_x_o,
  output logic signed [OutW-1:0] tangent_y_o,
  output logic signed [OutW-1:0] tangent_z_o,
  output logic signed [OutW-1:0] bitangent_x_o,
  output logic signed [OutW-1:0] bitangent_y_o,
  output logic signed [OutW-1:0] bitangent_z_o,
  output logic                   degenerate_o
);

  ttf_cmd_t cmd;
  ttf_sts_t sts;

  ttf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .tex_u_i       (tex_u_i),
    .tex_v_i       (tex_v_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .bitangent_x_o (bitangent_x_o),
    .bitangent_y_o (bitangent_y_o),
    .bitangent_z_o (bitangent_z_o),
    .degenerate_o  (degenerate_o)
  );

endmodule

// ----- sv/ttf_ctrl.sv -----
// Sequencer for the triangle tangent frame block.
// Depends on ttf_pkg; drives ttf_dp through ttf_cmd_t and reads ttf_sts_t.
`timescale 1ns / 1ps

module ttf_ctrl import ttf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ttf_sts_t sts_i,
  output ttf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StMul, StDetChk, StLoad, StVecChk, StShift, StSq,
    StSqrtInit, StSqrt, StDivInit, StDivStep, StDivWr, StDone
  } state_e;

  state_e     state_q;
  logic [1:0] corner_q;
  logic [4:0] cnt_q;
  logic [1:0] comp_q;
  logic       vec_q;
  logic       degen_q;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.hold_slot = corner_q[0];
    cmd_o.mul_idx   = cnt_q[MulIdxW-1:0];
    cmd_o.vec_sel   = vec_q;
    cmd_o.comp      = comp_q;
    cmd_o.out_degen = degen_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.hold_we = accept & (corner_q < 2'd2);
        cmd_o.start   = accept & (corner_q >= 2'd2);
      end
      StMul:      cmd_o.mul_issue = (cnt_q < 5'(NumProd));
      StLoad:     cmd_o.load_vec  = 1'b1;
      StShift:    cmd_o.shift     = sts_i.need_shift;
      StSq: begin
        cmd_o.sq_issue = (cnt_q < 5'd3);
        cmd_o.comp     = cnt_q[1:0];
      end
      StSqrtInit: cmd_o.sqrt_init = 1'b1;
      StSqrt:     cmd_o.sqrt_step = 1'b1;
      StDivInit:  cmd_o.div_init  = 1'b1;
      StDivStep:  cmd_o.div_step  = 1'b1;
      StDivWr:    cmd_o.div_wr    = 1'b1;
      StDone:     cmd_o.out_load  = ~sts_i.out_busy;
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      corner_q <= '0;
      cnt_q    <= '0;
      comp_q   <= '0;
      vec_q    <= 1'b0;
      degen_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (corner_q < 2'd2) begin
              corner_q <= corner_q + 2'd1;
            end else begin
              corner_q <= '0;
              cnt_q    <= '0;
              state_q  <= StMul;
            end
          end
        end
        StMul: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(NumProd)) state_q <= StDetChk;
        end
        StDetChk: begin
          vec_q <= 1'b0;
          if (sts_i.det_zero) begin
            degen_q <= 1'b1;
            state_q <= StDone;
          end else begin
            state_q <= StLoad;
          end
        end
        StLoad:   state_q <= StVecChk;
        StVecChk: begin
          if (sts_i.vec_zero) begin
            degen_q <= 1'b1;
            state_q <= StDone;
          end else begin
            state_q <= StShift;
          end
        end
        StShift: begin
          if (!sts_i.need_shift) begin
            cnt_q   <= '0;
            state_q <= StSq;
          end
        end
        StSq: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) state_q <= StSqrtInit;
        end
        StSqrtInit: begin
          cnt_q   <= '0;
          state_q <= StSqrt;
        end
        StSqrt: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            comp_q  <= '0;
            state_q <= StDivInit;
          end
        end
        StDivInit: begin
          cnt_q   <= '0;
          state_q <= StDivStep;
        end
        StDivStep: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) state_q <= StDivWr;
        end
        StDivWr: begin
          if (comp_q == 2'd2) begin
            if (vec_q) begin
              degen_q <= 1'b0;
              state_q <= StDone;
            end else begin
              vec_q   <= 1'b1;
              state_q <= StLoad;
            end
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= StDivInit;
          end
        end
        StDone: begin
          if (!sts_i.out_busy) begin
            degen_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- sv/ttf_dp.sv -----
// Datapath for the triangle tangent frame block: held vertices, shared
// multiplier, square-root and divider iterations, output register. Uses ttf_pkg.
`timescale 1ns / 1ps

module ttf_dp import ttf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ttf_cmd_t               cmd_i,
  output ttf_sts_t               sts_o,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic signed [TexW-1:0] tex_u_i,
  input  logic signed [TexW-1:0] tex_v_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] tangent_x_o,
  output logic signed [OutW-1:0] tangent_y_o,
  output logic signed [OutW-1:0] tangent_z_o,
  output logic signed [OutW-1:0] bitangent_x_o,
  output logic signed [OutW-1:0] bitangent_y_o,
  output logic signed [OutW-1:0] bitangent_z_o,
  output logic                   degenerate_o
);

  logic signed [PosW-1:0] pin [3];
  logic signed [PosW-1:0] p0_q [3];
  logic signed [PosW-1:0] p1_q [3];
  logic signed [TexW-1:0] uv0_q [2];
  logic signed [TexW-1:0] uv1_q [2];
  logic signed [PosW:0]   e1_q [3];
  logic signed [PosW:0]   e2_q [3];
  logic signed [TexW:0]   du1_q, dv1_q, du2_q, dv2_q;
  logic signed [42:0]     det_q;
  logic signed [56:0]     t_q [3];
  logic signed [56:0]     b_q [3];

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  // held vertices and edge/delta setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_we) begin
      if (cmd_i.hold_slot) begin
        for (int i = 0; i < 3; i++) p1_q[i] <= pin[i];
        uv1_q[0] <= tex_u_i;
        uv1_q[1] <= tex_v_i;
      end else begin
        for (int i = 0; i < 3; i++) p0_q[i] <= pin[i];
        uv0_q[0] <= tex_u_i;
        uv0_q[1] <= tex_v_i;
      end
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= {p1_q[i][PosW-1], p1_q[i]} - {p0_q[i][PosW-1], p0_q[i]};
        e2_q[i] <= {pin[i][PosW-1], pin[i]} - {p0_q[i][PosW-1], p0_q[i]};
      end
      du1_q <= {uv1_q[0][TexW-1], uv1_q[0]} - {uv0_q[0][TexW-1], uv0_q[0]};
      dv1_q <= {uv1_q[1][TexW-1], uv1_q[1]} - {uv0_q[1][TexW-1], uv0_q[1]};
      du2_q <= {tex_u_i[TexW-1], tex_u_i} - {uv0_q[0][TexW-1], uv0_q[0]};
      dv2_q <= {tex_v_i[TexW-1], tex_v_i} - {uv0_q[1][TexW-1], uv0_q[1]};
    end
  end

  // shared 21x33 multiplier: operand select per product index
  logic signed [TexW:0] ma;
  logic signed [PosW:0] mb;
  logic signed [53:0]   prod_d, prod_q;
  logic [MulIdxW-1:0]   pidx_q;
  logic                 ppend_q;

  always_comb begin
    ma = du1_q;
    mb = 33'(dv2_q);
    unique case (cmd_i.mul_idx)
      4'd0:  begin ma = du1_q; mb = 33'(dv2_q); end
      4'd1:  begin ma = dv1_q; mb = 33'(du2_q); end
      4'd2:  begin ma = dv2_q; mb = e1_q[0]; end
      4'd3:  begin ma = dv2_q; mb = e1_q[1]; end
      4'd4:  begin ma = dv2_q; mb = e1_q[2]; end
      4'd5:  begin ma = dv1_q; mb = e2_q[0]; end
      4'd6:  begin ma = dv1_q; mb = e2_q[1]; end
      4'd7:  begin ma = dv1_q; mb = e2_q[2]; end
      4'd8:  begin ma = du1_q; mb = e2_q[0]; end
      4'd9:  begin ma = du1_q; mb = e2_q[1]; end
      4'd10: begin ma = du1_q; mb = e2_q[2]; end
      4'd11: begin ma = du2_q; mb = e1_q[0]; end
      4'd12: begin ma = du2_q; mb = e1_q[1]; end
      4'd13: begin ma = du2_q; mb = e1_q[2]; end
      default: ;
    endcase
  end

  assign prod_d = ma * mb;

  logic signed [56:0] pext;
  assign pext = 57'(prod_q);

  // product register and accumulation into det, T and B
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppend_q <= 1'b0;
    end else begin
      ppend_q <= cmd_i.mul_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      prod_q <= prod_d;
      pidx_q <= cmd_i.mul_idx;
    end
    if (cmd_i.start) begin
      det_q <= '0;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= '0;
        b_q[i] <= '0;
      end
    end else if (ppend_q) begin
      unique case (pidx_q)
        4'd0:  det_q  <= det_q + 43'(prod_q);
        4'd1:  det_q  <= det_q - 43'(prod_q);
        4'd2:  t_q[0] <= t_q[0] + pext;
        4'd3:  t_q[1] <= t_q[1] + pext;
        4'd4:  t_q[2] <= t_q[2] + pext;
        4'd5:  t_q[0] <= t_q[0] - pext;
        4'd6:  t_q[1] <= t_q[1] - pext;
        4'd7:  t_q[2] <= t_q[2] - pext;
        4'd8:  b_q[0] <= b_q[0] + pext;
        4'd9:  b_q[1] <= b_q[1] + pext;
        4'd10: b_q[2] <= b_q[2] + pext;
        4'd11: b_q[0] <= b_q[0] - pext;
        4'd12: b_q[1] <= b_q[1] - pext;
        4'd13: b_q[2] <= b_q[2] - pext;
        default: ;
      endcase
    end
  end

  // magnitudes, sign and range reduction of the selected vector
  logic [55:0] mag_q [3];
  logic        sgn_q [3];
  logic [55:0] mag_or;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vec) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [56:0] v;
        v = cmd_i.vec_sel ? b_q[i] : t_q[i];
        mag_q[i] <= v[56] ? 56'(-v) : 56'(v);
        sgn_q[i] <= v[56] ^ det_q[42];
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
    end
  end

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

  // sum of squares, one 30x30 product per cycle
  logic [59:0] sq_q;
  logic        sqpend_q;
  logic [61:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqpend_q <= 1'b0;
    end else begin
      sqpend_q <= cmd_i.sq_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_issue) sq_q <= mag_q[cmd_i.comp][29:0] * mag_q[cmd_i.comp][29:0];
    if (cmd_i.load_vec)    sum_q <= '0;
    else if (sqpend_q)     sum_q <= sum_q + 62'(sq_q);
  end

  // integer square root, one result bit per cycle
  logic [61:0] n_q;
  logic [62:0] r_q, bit_q, trial;
  logic [31:0] len;

  assign trial = r_q + bit_q;
  assign len   = r_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      n_q   <= sum_q;
      r_q   <= '0;
      bit_q <= 63'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, n_q} >= trial) begin
        n_q <= n_q - trial[61:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // restoring divider: (mag*32768 + L) / (2L), 16 quotient bits
  logic [47:0] rem_q, dsh_q;
  logic [15:0] quo_q;
  logic signed [OutW-1:0] res_q [2][3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= 48'({mag_q[cmd_i.comp][29:0], 15'b0}) + 48'(len);
      dsh_q <= {len, 16'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        quo_q <= {quo_q[14:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.div_wr) begin
      res_q[cmd_i.vec_sel][cmd_i.comp] <= sgn_q[cmd_i.comp] ? -quo_q : quo_q;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      degenerate_o  <= cmd_i.out_degen;
      tangent_x_o   <= cmd_i.out_degen ? '0 : res_q[0][0];
      tangent_y_o   <= cmd_i.out_degen ? '0 : res_q[0][1];
      tangent_z_o   <= cmd_i.out_degen ? '0 : res_q[0][2];
      bitangent_x_o <= cmd_i.out_degen ? '0 : res_q[1][0];
      bitangent_y_o <= cmd_i.out_degen ? '0 : res_q[1][1];
      bitangent_z_o <= cmd_i.out_degen ? '0 : res_q[1][2];
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  assign sts_o.det_zero   = (det_q == '0);
  assign sts_o.vec_zero   = (mag_or == '0);
  assign sts_o.need_shift = |mag_or[55:30];
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

endmodule

// ----- test/triangle_tangent_frame_core_tb.sv -----
// Testbench for triangle_tangent_frame_core: drives a vertex stream and checks
// each tangent/bitangent result against a built-in integer predictor.
// Depends on ttf_pkg and the core RTL.
`timescale 1ns / 1ps

module triangle_tangent_frame_core_tb;
  import ttf_pkg::*;

  typedef struct packed {
    logic signed [OutW-1:0] tx, ty, tz, bx, by, bz;
    logic                   degen;
  } frame_t;

  // Frame predictor and store of expected frames
  class frame_board;
    logic [PosW-1:0] held_pos [6];
    logic [TexW-1:0] held_tex [4];
    int unsigned     corners;
    frame_t          pending [$];
    int              errors;

    function new();
      foreach (held_pos[i]) held_pos[i] = '0;
      foreach (held_tex[i]) held_tex[i] = '0;
      corners = 0;
      errors  = 0;
    endfunction

    // integer square root, floor
    function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // scale a raw vector to Q1.14 unit length; 0 for a zero vector
    function automatic bit unit_vec(input longint c[3], output longint o[3]);
      longint unsigned mag[3], m, sum, len, q;
      int s;
      m = 0;
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
        mag[i] >>= s;
        sum += mag[i] * mag[i];
      end
      len = root64(sum);
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 32768 + len) / (2 * len);
        o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void note_vertex(logic [PosW-1:0] px, py, pz, logic [TexW-1:0] u, v);
      longint e1[3], e2[3], t[3], b[3], tn[3], bn[3], p2[3];
      longint du1, dv1, du2, dv2, det;
      bit ok;
      frame_t f;
      int k;
      if (corners < 2) begin
        k = corners & 1;
        held_pos[k*3] = px;
        held_pos[k*3+1] = py;
        held_pos[k*3+2] = pz;
        held_tex[k*2] = u;
        held_tex[k*2+1] = v;
        corners++;
        return;
      end
      corners = 0;
      p2[0] = longint'(signed'(px));
      p2[1] = longint'(signed'(py));
      p2[2] = longint'(signed'(pz));
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(signed'(held_pos[3+i])) - longint'(signed'(held_pos[i]));
        e2[i] = p2[i] - longint'(signed'(held_pos[i]));
      end
      du1 = longint'(signed'(held_tex[2])) - longint'(signed'(held_tex[0]));
      dv1 = longint'(signed'(held_tex[3])) - longint'(signed'(held_tex[1]));
      du2 = longint'(signed'(u)) - longint'(signed'(held_tex[0]));
      dv2 = longint'(signed'(v)) - longint'(signed'(held_tex[1]));
      det = du1 * dv2 - dv1 * du2;
      for (int i = 0; i < 3; i++) begin
        t[i] = dv2 * e1[i] - dv1 * e2[i];
        b[i] = du1 * e2[i] - du2 * e1[i];
        if (det < 0) begin
          t[i] = -t[i];
          b[i] = -b[i];
        end
      end
      ok = det != 0;
      if (ok) ok = unit_vec(t, tn);
      if (ok) ok = unit_vec(b, bn);
      f = '0;
      f.degen = !ok;
      if (ok) begin
        f.tx = tn[0][15:0];
        f.ty = tn[1][15:0];
        f.tz = tn[2][15:0];
        f.bx = bn[0][15:0];
        f.by = bn[1][15:0];
        f.bz = bn[2][15:0];
      end
      pending = {pending, f};
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [PosW-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [TexW-1:0] tex_u_i, tex_v_i;
  logic signed [OutW-1:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [OutW-1:0] bitangent_x_o, bitangent_y_o, bitangent_z_o;
  logic degenerate_o;

  frame_board board;
  bit quiet;   // no idle bursts or output stalls in the last part
  bit stim_done;

  triangle_tangent_frame_core u_top (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // one vertex, with an optional idle burst ahead of it; valid stays high
  // between back-to-back vertices
  task automatic send_vertex(logic [PosW-1:0] px, py, pz, logic [TexW-1:0] u, v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    tex_u_i <= u;
    tex_v_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_vertex(px, py, pz, u, v);
  endtask

  function automatic logic [PosW-1:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 2000) - 1000;
      default: return {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
    endcase
  endfunction

  task automatic send_triangle();
    int mode;
    logic [TexW-1:0] u0, v0;
    mode = $urandom_range(0, 4);
    u0 = 20'($urandom());
    v0 = 20'($urandom());
    for (int k = 0; k < 3; k++) begin
      if (mode == 4)   // collinear UVs force a zero determinant
        send_vertex(rand_pos(0), rand_pos(1), rand_pos(2), 20'(u0 + k), 20'(v0 + 2 * k));
      else if (mode == 3)
        send_vertex(rand_pos(1), rand_pos(1), rand_pos(1),
                    20'($urandom_range(0, 64) - 32), 20'($urandom_range(0, 64) - 32));
      else
        send_vertex(rand_pos(mode), rand_pos(2), rand_pos(0),
                    20'($urandom()), 20'($urandom()));
    end
  endtask

  // result side with random stalls
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_frame({tangent_x_o, tangent_y_o, tangent_z_o,
                           bitangent_x_o, bitangent_y_o, bitangent_z_o, degenerate_o});
    end
  end

  // stimulus
  initial begin
    board = new();
    quiet = 0;
    stim_done = 0;
    rst_ni = 0;
    in_valid_i = 0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    tex_u_i = '0;
    tex_v_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: unit triangle, extremes, all-zero, zero-area
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h0001_0000, 0, 0, 20'h10000, 0);
    send_vertex(0, 32'h0001_0000, 0, 0, 20'h10000);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 20'h80000, 20'h7ffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 20'h7ffff, 20'h80000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 20'h80000, 20'h80000);
    send_vertex(5, 5, 5, 1, 1);
    send_vertex(5, 5, 5, 2, 3);
    send_vertex(5, 5, 5, 7, 2);
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(1, 2, 3, 0, 0);
    send_vertex(4, 5, 6, 0, 0);
    send_vertex(32'hffff_ffff, 0, 0, 20'hfffff, 0);
    send_vertex(0, 32'hffff_ffff, 0, 0, 20'hfffff);
    send_vertex(0, 0, 32'hffff_ffff, 20'h00001, 20'h00001);
    in_valid_i <= 0;
    // pause until every expected frame has come
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 400; n++) begin
      if (n == 340) quiet = 1;
      send_triangle();
    end
    in_valid_i <= 0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
